### rtl/assert_macros.svh
// assertion helpers shared by the rtl; empty bodies under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every sampled edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// condition in one cycle forces a result in the next
`define ASSERT_NEXT(lbl, clk, rst_n, cond, res) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, cond, res)

`endif

`endif

### rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Constants shared by the 1-Wire bus master: register map, defaults, tails, command codes.
// ----------------------------------------------------------------------------
package owbm_pkg;

	localparam int unsigned REG_W   = 10;
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned IDX_W   = 3;

	typedef logic [REG_W-1:0] reg_val_t;
	typedef logic [IDX_W-1:0] reg_idx_t;

	// register indexes
	localparam reg_idx_t REG_RESET_LOW     = 3'd0;
	localparam reg_idx_t REG_PRESENCE_SAMP = 3'd1;
	localparam reg_idx_t REG_RESET_REC     = 3'd2;
	localparam reg_idx_t REG_WR1_LOW       = 3'd3;
	localparam reg_idx_t REG_WR0_LOW       = 3'd4;
	localparam reg_idx_t REG_RD_LOW        = 3'd5;
	localparam reg_idx_t REG_RD_SAMPLE     = 3'd6;
	localparam reg_idx_t REG_RD_TAIL       = 3'd7;

	// register reset values
	localparam reg_val_t DEF_RESET_LOW     = 10'd480;
	localparam reg_val_t DEF_PRESENCE_SAMP = 10'd70;
	localparam reg_val_t DEF_RESET_REC     = 10'd410;
	localparam reg_val_t DEF_WR1_LOW       = 10'd6;
	localparam reg_val_t DEF_WR0_LOW       = 10'd60;
	localparam reg_val_t DEF_RD_LOW        = 10'd2;
	localparam reg_val_t DEF_RD_SAMPLE     = 10'd10;
	localparam reg_val_t DEF_RD_TAIL       = 10'd50;

	// fixed write slot tails
	localparam reg_val_t TAIL_ONE  = 10'd64;
	localparam reg_val_t TAIL_ZERO = 10'd10;

	// command codes
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_RESET = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

endpackage

### rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Open-drain 1-Wire master stepped once per microsecond tick: reset/presence,
// byte write and byte read slots, lsb first, with programmable slot timing.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------
//  s_*     | in  | tvalid / tready  | one tick: tuser=mode, tdata=byte,level
//  m_*     | out | tvalid / tready  | one status word per tick
//  cfg_*   | in  | we only          | timing register write
//
// One tick is accepted per cycle while s_tready is high; its status word appears
// the next cycle in the output register, set by the combinational phase/counter update.
// s_tready drops only while a status word waits and m_tready is low.
// Reset (arst_n) returns to idle, clears status and loads default timings.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
	parameter int unsigned TIME_WIDTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // write_data[7:0], line_level[8], zeros
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // drive_low[0], busy_res[1], done_res[2],
	                               // presence[3], read_data[11:4],
	                               // command_rejected[12], zeros
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	localparam int unsigned CMP_W =
		((TIME_WIDTH > owbm_pkg::REG_W) ? TIME_WIDTH : owbm_pkg::REG_W) + 1;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_RLOW   = 4'd1,
		PH_RWAIT  = 4'd2,
		PH_RREC   = 4'd3,
		PH_WLOW   = 4'd4,
		PH_WTAIL  = 4'd5,
		PH_RDLOW  = 4'd6,
		PH_RDWAIT = 4'd7,
		PH_RDTAIL = 4'd8
	} phase_t;

	owbm_pkg::reg_val_t regs_q [owbm_pkg::NUM_REGS];

	phase_t                phase_q;
	logic [TIME_WIDTH-1:0] time_count_q;
	logic [2:0]            bit_index_q;
	logic [7:0]            shift_byte_q;
	logic                  presence_q;
	logic [7:0]            read_byte_q;
	logic                  out_valid_q;
	logic [15:0]           out_data_q;

	owbm_pkg::mode_t mode;
	logic [7:0]      wd;
	logic            lvl;
	logic            accept;

	phase_t                ph_c, ph_n;
	logic [TIME_WIDTH-1:0] tc_c, tc_n;
	logic [2:0]            bi_c, bi_n;
	logic [7:0]            sb_c, sb_n;
	logic                  pres_n;
	logic [7:0]            rdb_n;
	logic                  rej, done, drive, busy, moved;
	owbm_pkg::reg_val_t    dur;

	// a phase of d ticks ends on its last tick, zero acts as one
	function automatic logic phase_over(input logic [TIME_WIDTH-1:0] tc,
			input owbm_pkg::reg_val_t d);
		logic [CMP_W-1:0] sum;
		sum = CMP_W'(tc) + CMP_W'(1);
		return sum >= CMP_W'(d);
	endfunction

	assign mode   = owbm_pkg::mode_t'(s_tuser);
	assign wd     = s_tdata[7:0];
	assign lvl    = s_tdata[8];
	assign s_tready = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		// command start is folded into the same tick
		ph_c = phase_q;
		tc_c = time_count_q;
		bi_c = bit_index_q;
		sb_c = shift_byte_q;
		rej  = 1'b0;
		if (phase_q == PH_IDLE) begin
			tc_c = '0;
			case (mode)
				owbm_pkg::MODE_RESET: ph_c = PH_RLOW;
				owbm_pkg::MODE_WRITE: begin
					ph_c = PH_WLOW;
					sb_c = wd;
					bi_c = 3'd0;
				end
				owbm_pkg::MODE_READ: begin
					ph_c = PH_RDLOW;
					sb_c = 8'd0;
					bi_c = 3'd0;
				end
				default: ph_c = PH_IDLE;
			endcase
		end else if (mode != owbm_pkg::MODE_TICK) begin
			rej = 1'b1;
		end

		ph_n   = ph_c;
		bi_n   = bi_c;
		sb_n   = sb_c;
		pres_n = presence_q;
		rdb_n  = read_byte_q;
		done   = 1'b0;
		moved  = 1'b0;
		busy   = (ph_c != PH_IDLE);
		drive  = (ph_c == PH_RLOW) || (ph_c == PH_WLOW) || (ph_c == PH_RDLOW);
		dur    = '0;

		unique case (ph_c)
			PH_IDLE: ;
			PH_RLOW: begin
				dur = regs_q[owbm_pkg::REG_RESET_LOW];
				if (phase_over(tc_c, dur)) begin
					ph_n  = PH_RWAIT;
					moved = 1'b1;
				end
			end
			PH_RWAIT: begin
				dur = regs_q[owbm_pkg::REG_PRESENCE_SAMP];
				if (phase_over(tc_c, dur)) begin
					ph_n  = PH_RREC;
					moved = 1'b1;
				end
			end
			PH_RREC: begin
				dur = regs_q[owbm_pkg::REG_RESET_REC];
				if (tc_c == '0) pres_n = !lvl;
				if (phase_over(tc_c, dur)) begin
					done  = 1'b1;
					ph_n  = PH_IDLE;
					moved = 1'b1;
				end
			end
			PH_WLOW: begin
				dur = sb_c[0] ? regs_q[owbm_pkg::REG_WR1_LOW] : regs_q[owbm_pkg::REG_WR0_LOW];
				if (phase_over(tc_c, dur)) begin
					ph_n  = PH_WTAIL;
					moved = 1'b1;
				end
			end
			PH_WTAIL: begin
				dur = sb_c[0] ? owbm_pkg::TAIL_ONE : owbm_pkg::TAIL_ZERO;
				if (phase_over(tc_c, dur)) begin
					sb_n  = {1'b0, sb_c[7:1]};
					moved = 1'b1;
					if (bi_c == 3'd7) begin
						done = 1'b1;
						ph_n = PH_IDLE;
					end else begin
						bi_n = bi_c + 3'd1;
						ph_n = PH_WLOW;
					end
				end
			end
			PH_RDLOW: begin
				dur = regs_q[owbm_pkg::REG_RD_LOW];
				if (phase_over(tc_c, dur)) begin
					// zero sample time skips the wait
					ph_n  = (regs_q[owbm_pkg::REG_RD_SAMPLE] == '0) ? PH_RDTAIL : PH_RDWAIT;
					moved = 1'b1;
				end
			end
			PH_RDWAIT: begin
				dur = regs_q[owbm_pkg::REG_RD_SAMPLE];
				if (phase_over(tc_c, dur)) begin
					ph_n  = PH_RDTAIL;
					moved = 1'b1;
				end
			end
			PH_RDTAIL: begin
				dur = regs_q[owbm_pkg::REG_RD_TAIL];
				if (tc_c == '0) sb_n = {lvl, sb_c[7:1]};
				if (phase_over(tc_c, dur)) begin
					moved = 1'b1;
					if (bi_c == 3'd7) begin
						rdb_n = sb_n;
						done  = 1'b1;
						ph_n  = PH_IDLE;
					end else begin
						bi_n = bi_c + 3'd1;
						ph_n = PH_RDLOW;
					end
				end
			end
			default: begin
				busy  = 1'b0;
				drive = 1'b0;
				ph_n  = PH_IDLE;
				moved = 1'b1;
			end
		endcase

		if (ph_c == PH_IDLE) tc_n = '0;
		else if (moved)      tc_n = '0;
		else                 tc_n = tc_c + TIME_WIDTH'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[owbm_pkg::REG_RESET_LOW]     <= owbm_pkg::DEF_RESET_LOW;
			regs_q[owbm_pkg::REG_PRESENCE_SAMP] <= owbm_pkg::DEF_PRESENCE_SAMP;
			regs_q[owbm_pkg::REG_RESET_REC]     <= owbm_pkg::DEF_RESET_REC;
			regs_q[owbm_pkg::REG_WR1_LOW]       <= owbm_pkg::DEF_WR1_LOW;
			regs_q[owbm_pkg::REG_WR0_LOW]       <= owbm_pkg::DEF_WR0_LOW;
			regs_q[owbm_pkg::REG_RD_LOW]        <= owbm_pkg::DEF_RD_LOW;
			regs_q[owbm_pkg::REG_RD_SAMPLE]     <= owbm_pkg::DEF_RD_SAMPLE;
			regs_q[owbm_pkg::REG_RD_TAIL]       <= owbm_pkg::DEF_RD_TAIL;
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			time_count_q <= '0;
			bit_index_q  <= 3'd0;
			shift_byte_q <= 8'd0;
			presence_q   <= 1'b0;
			read_byte_q  <= 8'd0;
			out_valid_q  <= 1'b0;
			out_data_q   <= 16'd0;
		end else begin
			if (accept) begin
				phase_q      <= ph_n;
				time_count_q <= tc_n;
				bit_index_q  <= bi_n;
				shift_byte_q <= sb_n;
				presence_q   <= pres_n;
				read_byte_q  <= rdb_n;
				out_data_q   <= {3'd0, rej, rdb_n, pres_n, done, busy, drive};
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_done_busy, clk, arst_n, !out_valid_q || !out_data_q[2] || out_data_q[1])
	`ASSERT_ALWAYS(a_drive_busy, clk, arst_n, !out_valid_q || !out_data_q[0] || out_data_q[1])
	`ASSERT_ALWAYS(a_idle_count, clk, arst_n, (phase_q != PH_IDLE) || (time_count_q == '0))
	`ASSERT_NEXT(a_reject, clk, arst_n,
		accept && (phase_q != PH_IDLE) && (mode != owbm_pkg::MODE_TICK),
		out_valid_q && out_data_q[12])

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench for one_wire_bus_master
// Drives one-microsecond ticks (mode, byte, sampled line level) into the
// master and checks every status word against a cycle-free slot-timing model
// kept in a scoreboard. Directed commands cover the default timing, zero
// timings and commands that arrive while busy. Random segments follow, each
// under a fresh timing set, with input gaps and output stalls varied between
// phases.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SEG_TICKS   = 20;
	localparam int MAX_REPORTS = 10;

	localparam int LINE_LOW    = 0;
	localparam int LINE_HIGH   = 1;
	localparam int LINE_RANDOM = 2;

	localparam owbm_pkg::reg_idx_t REG_ORDER [owbm_pkg::NUM_REGS] = '{
		owbm_pkg::REG_RESET_LOW, owbm_pkg::REG_PRESENCE_SAMP, owbm_pkg::REG_RESET_REC,
		owbm_pkg::REG_WR1_LOW, owbm_pkg::REG_WR0_LOW, owbm_pkg::REG_RD_LOW,
		owbm_pkg::REG_RD_SAMPLE, owbm_pkg::REG_RD_TAIL};

	typedef enum logic [3:0] {
		PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC, PH_WR_LOW, PH_WR_TAIL,
		PH_RD_LOW, PH_RD_WAIT, PH_RD_TAIL
	} slot_phase_t;

	// status word layout, lowest bit last
	typedef struct packed {
		logic [2:0] pad;
		logic       rejected;
		logic [7:0] rd_byte;
		logic       present;
		logic       done;
		logic       busy;
		logic       drive;
	} status_t;

	class link_scoreboard;
		owbm_pkg::reg_val_t timing [owbm_pkg::NUM_REGS];
		slot_phase_t phase;
		int unsigned t_cnt;
		logic [2:0]  bit_cnt;
		logic [7:0]  shreg;
		logic [7:0]  rd_q;
		logic        present_q;
		status_t     expected [$];
		int          mismatches;

		function new();
			timing[owbm_pkg::REG_RESET_LOW]     = owbm_pkg::DEF_RESET_LOW;
			timing[owbm_pkg::REG_PRESENCE_SAMP] = owbm_pkg::DEF_PRESENCE_SAMP;
			timing[owbm_pkg::REG_RESET_REC]     = owbm_pkg::DEF_RESET_REC;
			timing[owbm_pkg::REG_WR1_LOW]       = owbm_pkg::DEF_WR1_LOW;
			timing[owbm_pkg::REG_WR0_LOW]       = owbm_pkg::DEF_WR0_LOW;
			timing[owbm_pkg::REG_RD_LOW]        = owbm_pkg::DEF_RD_LOW;
			timing[owbm_pkg::REG_RD_SAMPLE]     = owbm_pkg::DEF_RD_SAMPLE;
			timing[owbm_pkg::REG_RD_TAIL]       = owbm_pkg::DEF_RD_TAIL;
			phase = PH_IDLE;
			t_cnt = 0;
			bit_cnt = '0;
			shreg = '0;
			rd_q = '0;
			present_q = 1'b0;
			mismatches = 0;
		endfunction

		function bit idle();
			return phase == PH_IDLE;
		endfunction

		function int outstanding();
			return expected.size();
		endfunction

		// a slot phase of dur ticks ends on its last tick; zero counts as one
		function bit slot_over(int unsigned dur);
			return t_cnt + 1 >= dur;
		endfunction

		function void note_tick(owbm_pkg::mode_t mode, logic [7:0] wd, logic lvl);
			status_t     st;
			bit          moved;
			slot_phase_t nxt;
			st = '0;
			moved = 1'b0;
			nxt = PH_IDLE;
			if (phase == PH_IDLE) begin
				case (mode)
					owbm_pkg::MODE_RESET: phase = PH_RST_LOW;
					owbm_pkg::MODE_WRITE: begin
						shreg = wd;
						bit_cnt = '0;
						phase = PH_WR_LOW;
					end
					owbm_pkg::MODE_READ: begin
						shreg = '0;
						bit_cnt = '0;
						phase = PH_RD_LOW;
					end
					default: ;
				endcase
				t_cnt = 0;
			end else if (mode != owbm_pkg::MODE_TICK) begin
				st.rejected = 1'b1;
			end
			if (phase != PH_IDLE) begin
				st.busy = 1'b1;
				st.drive = (phase == PH_RST_LOW || phase == PH_WR_LOW || phase == PH_RD_LOW);
				case (phase)
					PH_RST_LOW: if (slot_over(timing[owbm_pkg::REG_RESET_LOW])) begin
						nxt = PH_RST_WAIT;
						moved = 1'b1;
					end
					PH_RST_WAIT: if (slot_over(timing[owbm_pkg::REG_PRESENCE_SAMP])) begin
						nxt = PH_RST_REC;
						moved = 1'b1;
					end
					PH_RST_REC: begin
						// a device pulling the line low answers the reset
						if (t_cnt == 0)
							present_q = !lvl;
						if (slot_over(timing[owbm_pkg::REG_RESET_REC])) begin
							st.done = 1'b1;
							moved = 1'b1;
						end
					end
					PH_WR_LOW: if (slot_over(shreg[0] ? timing[owbm_pkg::REG_WR1_LOW]
							: timing[owbm_pkg::REG_WR0_LOW])) begin
						nxt = PH_WR_TAIL;
						moved = 1'b1;
					end
					PH_WR_TAIL: if (slot_over(shreg[0] ? owbm_pkg::TAIL_ONE
							: owbm_pkg::TAIL_ZERO)) begin
						shreg = shreg >> 1;
						moved = 1'b1;
						if (bit_cnt == 3'd7) begin
							st.done = 1'b1;
						end else begin
							bit_cnt++;
							nxt = PH_WR_LOW;
						end
					end
					PH_RD_LOW: if (slot_over(timing[owbm_pkg::REG_RD_LOW])) begin
						nxt = (timing[owbm_pkg::REG_RD_SAMPLE] == '0) ? PH_RD_TAIL
							: PH_RD_WAIT;
						moved = 1'b1;
					end
					PH_RD_WAIT: if (slot_over(timing[owbm_pkg::REG_RD_SAMPLE])) begin
						nxt = PH_RD_TAIL;
						moved = 1'b1;
					end
					PH_RD_TAIL: begin
						if (t_cnt == 0)
							shreg = {lvl, shreg[7:1]};
						if (slot_over(timing[owbm_pkg::REG_RD_TAIL])) begin
							moved = 1'b1;
							if (bit_cnt == 3'd7) begin
								rd_q = shreg;
								st.done = 1'b1;
							end else begin
								bit_cnt++;
								nxt = PH_RD_LOW;
							end
						end
					end
					default: begin
						st.busy = 1'b0;
						st.drive = 1'b0;
						moved = 1'b1;
					end
				endcase
				if (moved) begin
					phase = nxt;
					t_cnt = 0;
				end else begin
					t_cnt = (t_cnt + 1) & 32'h3FF;
				end
			end
			st.present = present_q;
			st.rd_byte = rd_q;
			expected.push_back(st);
		endfunction

		function string show(status_t s);
			return $sformatf("drive=%0b busy=%0b done=%0b presence=%0b read_data=%02h rej=%0b pad=%0h",
				s.drive, s.busy, s.done, s.present, s.rd_byte, s.rejected, s.pad);
		endfunction

		function void check_status(logic [15:0] word);
			status_t act;
			status_t exp;
			act = status_t'(word);
			if (expected.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t unexpected status word: %s", $time, show(act));
				mismatches++;
				return;
			end
			exp = expected.pop_front();
			if (act.drive !== exp.drive || act.busy !== exp.busy || act.done !== exp.done
					|| act.present !== exp.present || act.rd_byte !== exp.rd_byte
					|| act.rejected !== exp.rejected || act.pad !== exp.pad) begin
				if (mismatches < MAX_REPORTS) begin
					$display("%0t status mismatch", $time);
					$display("  expected %s", show(exp));
					$display("  actual   %s", show(act));
				end
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [9:0]  cfg_data;

	link_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int line_policy;

	one_wire_bus_master uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_status(m_tdata);
	end

	function automatic logic pick_level();
		case (line_policy)
			LINE_LOW:  return 1'b0;
			LINE_HIGH: return 1'b1;
			default:   return 1'($urandom);
		endcase
	endfunction

	// entered and left just after a falling edge
	task automatic send_tick(input owbm_pkg::mode_t mode, input logic [7:0] wd,
			input logic lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {7'd0, lvl, wd};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(mode, wd, lvl);
		@(negedge clk);
	endtask

	// timing is only rewritten with the master idle and every word back
	task automatic load_timing(input owbm_pkg::reg_val_t vals [owbm_pkg::NUM_REGS]);
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(negedge clk);
		for (int i = 0; i < owbm_pkg::NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data <= vals[i];
			sb.timing[REG_ORDER[i]] = vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_op(input owbm_pkg::mode_t mode, input logic [7:0] wd);
		send_tick(mode, wd, pick_level());
		while (!sb.idle())
			send_tick(owbm_pkg::MODE_TICK, 8'($urandom), pick_level());
	endtask

	// every tick of the operation, the done tick too, carries another command
	task automatic hammer_op(input owbm_pkg::mode_t mode);
		send_tick(mode, 8'($urandom), pick_level());
		while (!sb.idle())
			send_tick(owbm_pkg::mode_t'($urandom_range(1, 3)), 8'($urandom), pick_level());
	endtask

	function automatic owbm_pkg::reg_val_t rand_timing();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 85)
			return owbm_pkg::reg_val_t'($urandom_range(1, 6));
		if (r < 97)
			return owbm_pkg::reg_val_t'($urandom_range(7, 40));
		return owbm_pkg::reg_val_t'($urandom_range(41, 120));
	endfunction

	task automatic random_segment(input int n_ticks);
		int              sent;
		owbm_pkg::mode_t mode;
		sent = 0;
		while (sent < n_ticks || !sb.idle()) begin
			if (sb.idle() && sent < n_ticks)
				mode = ($urandom_range(99) < 88) ? owbm_pkg::mode_t'($urandom_range(1, 3))
					: owbm_pkg::MODE_TICK;
			else if (!sb.idle() && $urandom_range(99) < 6)
				mode = owbm_pkg::mode_t'($urandom_range(1, 3));
			else
				mode = owbm_pkg::MODE_TICK;
			send_tick(mode, 8'($urandom), 1'($urandom));
			sent++;
		end
	endtask

	initial begin
		owbm_pkg::reg_val_t vals [owbm_pkg::NUM_REGS];
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = owbm_pkg::MODE_TICK;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = owbm_pkg::REG_RESET_LOW;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		line_policy = LINE_RANDOM;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default timing straight out of reset
		repeat (3) send_tick(owbm_pkg::MODE_TICK, 8'($urandom), pick_level());
		run_op(owbm_pkg::MODE_READ, 8'h3C);

		// zero timings: shortest phases, read wait skipped
		foreach (vals[i]) vals[i] = '0;
		load_timing(vals);
		line_policy = LINE_LOW;
		run_op(owbm_pkg::MODE_RESET, 8'h00);
		line_policy = LINE_RANDOM;
		run_op(owbm_pkg::MODE_WRITE, 8'h00);
		run_op(owbm_pkg::MODE_READ, 8'h00);
		hammer_op(owbm_pkg::MODE_RESET);
		hammer_op(owbm_pkg::MODE_WRITE);
		hammer_op(owbm_pkg::MODE_READ);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 65; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 65; end
				default: begin send_idle_pct = 12; stall_pct = 12; end
			endcase
			for (int s = 0; s < 2; s++) begin
				foreach (vals[i]) vals[i] = rand_timing();
				load_timing(vals);
				random_segment(SEG_TICKS);
			end
		end

		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
